// ----- sv/vtls_pkg.sv -----
// ----------------------------------------------------------------------------
// Vector type and length setter package
// Shared payload types, register indexes, type-word field positions and the
// helper that builds the illegal type pattern.
// ----------------------------------------------------------------------------
`default_nettype none

package vtls_pkg;

  // Default sizing of the vector unit.
  localparam int unsigned VECTOR_BITS_DEF  = 256;
  localparam int unsigned ELEMENT_BITS_DEF = 64;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 7;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTEGER_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALT_FORMAT_OK_BYTE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALT_FORMAT_OK_HALF = 2'd2;

  // Reset value of the integer width register.
  localparam logic [CFG_DATA_W-1:0] INTEGER_WIDTH_RESET = 7'd64;

  // Type word layout.
  localparam int unsigned TYPE_W        = 64;
  localparam int unsigned TYPE_MUL_LSB  = 0;
  localparam int unsigned TYPE_SEW_LSB  = 3;
  localparam int unsigned TYPE_ALT_BIT  = 8;
  localparam int unsigned TYPE_RSVD_LSB = 9;

  // Multiplier code that stands for 1/16, which is never legal.
  localparam logic [2:0] MUL_CODE_SIXTEENTH = 3'd4;

  // Element width codes that the alternate format may use.
  localparam logic [2:0] SEW_CODE_BYTE = 3'd0;
  localparam logic [2:0] SEW_CODE_HALF = 3'd1;

  // Output length fields are 9 bits wide.
  localparam int unsigned OUT_LEN_W = 9;

  // One request beat.
  typedef struct packed {
    logic               dest_nonzero;
    logic               source_nonzero;
    logic [63:0]        requested_length;
    logic [TYPE_W-1:0]  requested_type;
  } request_t;

  // One result beat.
  typedef struct packed {
    logic [OUT_LEN_W-1:0] new_length;
    logic [TYPE_W-1:0]    type_value;
    logic                 type_illegal;
    logic [OUT_LEN_W-1:0] max_length;
  } result_t;

  // Illegal type pattern: all ones from bit (integer width - 1) upward.
  // Integer widths outside 1..64 place the bit as for 64.
  function automatic logic [TYPE_W-1:0] illegal_pattern(input logic [CFG_DATA_W-1:0] xw);
    logic [5:0] sh;
    if (xw >= 7'd1 && xw <= 7'd64) begin
      sh = 6'(xw - 7'd1);
    end else begin
      sh = 6'd63;
    end
    return {TYPE_W{1'b1}} << sh;
  endfunction

endpackage

`default_nettype wire

// ----- sv/vtls_type_decode.sv -----
// ----------------------------------------------------------------------------
// Vector type decoder
// Decodes a requested type word into its maximum length and flags every
// property of the word itself that makes it illegal.
// ----------------------------------------------------------------------------
`default_nettype none

module vtls_type_decode #(
  parameter int unsigned VECTOR_BITS  = vtls_pkg::VECTOR_BITS_DEF,
  parameter int unsigned ELEMENT_BITS = vtls_pkg::ELEMENT_BITS_DEF,
  parameter int unsigned LEN_W        = $clog2(VECTOR_BITS + 1)
) (
  input  wire logic [vtls_pkg::TYPE_W-1:0] type_word,
  input  wire logic                        alt_format_ok_byte,
  input  wire logic                        alt_format_ok_half,
  output logic      [LEN_W-1:0]            new_max,
  output logic                             type_bad
);

  logic [2:0]       mul_code;
  logic [2:0]       sew_code;
  logic             alt;
  logic             reserved;
  logic [2:0]       frac_shift;
  logic [LEN_W-1:0] per_reg;
  logic [14:0]      sew;
  logic [14:0]      sew_scaled;
  logic             bad_sew;
  logic             alt_ok;

  // Field extraction.
  assign mul_code = type_word[vtls_pkg::TYPE_MUL_LSB +: 3];
  assign sew_code = type_word[vtls_pkg::TYPE_SEW_LSB +: 3];
  assign alt      = type_word[vtls_pkg::TYPE_ALT_BIT];
  assign reserved = |type_word[vtls_pkg::TYPE_W-1:vtls_pkg::TYPE_RSVD_LSB];

  // For fractional multipliers the shift is 8 minus the code, i.e. its negation mod 8.
  assign frac_shift = 3'd0 - mul_code;

  // Elements per register, one constant per element width code.
  always_comb begin
    case (sew_code)
      3'd0:    per_reg = LEN_W'(VECTOR_BITS / 8);
      3'd1:    per_reg = LEN_W'(VECTOR_BITS / 16);
      3'd2:    per_reg = LEN_W'(VECTOR_BITS / 32);
      3'd3:    per_reg = LEN_W'(VECTOR_BITS / 64);
      3'd4:    per_reg = LEN_W'(VECTOR_BITS / 128);
      3'd5:    per_reg = LEN_W'(VECTOR_BITS / 256);
      3'd6:    per_reg = LEN_W'(VECTOR_BITS / 512);
      default: per_reg = LEN_W'(VECTOR_BITS / 1024);
    endcase
  end

  // Maximum length and element width check, integer or fractional multiplier.
  assign sew        = 15'd8 << sew_code;
  assign sew_scaled = sew << frac_shift;

  always_comb begin
    if (!mul_code[2]) begin
      new_max = per_reg << mul_code[1:0];
      bad_sew = sew > 15'(ELEMENT_BITS);
    end else begin
      new_max = per_reg >> frac_shift;
      bad_sew = sew_scaled > 15'(ELEMENT_BITS);
    end
  end

  // The alternate format is only allowed where an extension permits it.
  assign alt_ok = (alt_format_ok_byte && sew_code == vtls_pkg::SEW_CODE_BYTE)
               || (alt_format_ok_half && sew_code == vtls_pkg::SEW_CODE_HALF);

  assign type_bad = (mul_code == vtls_pkg::MUL_CODE_SIXTEENTH) || bad_sew || reserved
                 || (alt && !alt_ok);

endmodule

`default_nettype wire

// ----- sv/vector_type_and_length_setter.sv -----
// ----------------------------------------------------------------------------
// Vector type and length setter
// Executes vector configuration requests: decodes and checks the requested
// type, keeps the current type, maximum length and length, and reports them.
// A request beat passes the request register, then the result register.
// Throughput: one request per cycle when res_stall is low; the type compare,
// decode and length update fit between the request and result registers.
// Reset (synchronous): type takes the illegal pattern for a 64-bit integer
// width, both lengths clear, configuration returns to its reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_type_and_length_setter #(
  parameter int unsigned VECTOR_BITS  = vtls_pkg::VECTOR_BITS_DEF,
  parameter int unsigned ELEMENT_BITS = vtls_pkg::ELEMENT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Request channel.
  input  wire logic                             req_valid,
  output logic                                  req_stall,
  input  wire vtls_pkg::request_t               req_data,
  // Result channel.
  output logic                                  res_valid,
  input  wire logic                             res_stall,
  output vtls_pkg::result_t                     res_data,
  // Configuration write channel.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [vtls_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [vtls_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned LEN_W = $clog2(VECTOR_BITS + 1);

  // Configuration registers.
  logic [vtls_pkg::CFG_DATA_W-1:0] integer_width;
  logic                            alt_format_ok_byte;
  logic                            alt_format_ok_half;

  // Request register.
  logic               req_held;
  vtls_pkg::request_t req_reg;

  // Architectural state.
  logic [vtls_pkg::TYPE_W-1:0] current_type;
  logic [LEN_W-1:0]            current_max_length;
  logic [LEN_W-1:0]            current_length;
  logic [vtls_pkg::TYPE_W-1:0] current_type_next;
  logic [LEN_W-1:0]            current_max_length_next;
  logic [LEN_W-1:0]            current_length_next;

  // Decode results and control.
  logic [LEN_W-1:0]   new_max;
  logic               type_bad;
  logic               illegal;
  logic               advance;
  logic               keep_length;
  logic [LEN_W+8:0]   length_ext;
  logic [LEN_W+8:0]   max_ext;
  vtls_pkg::result_t  res_data_next;

  // The result register moves whenever it is empty or being drained.
  assign advance   = !res_valid || !res_stall;
  assign req_stall = req_held && !advance;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      integer_width      <= vtls_pkg::INTEGER_WIDTH_RESET;
      alt_format_ok_byte <= 1'b0;
      alt_format_ok_half <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vtls_pkg::CFG_INTEGER_WIDTH:      integer_width      <= cfg_data;
        vtls_pkg::CFG_ALT_FORMAT_OK_BYTE: alt_format_ok_byte <= cfg_data[0];
        vtls_pkg::CFG_ALT_FORMAT_OK_HALF: alt_format_ok_half <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Request register: loads a new beat whenever it is empty or moving on.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_held <= 1'b0;
    end else if (!req_stall) begin
      req_held <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_reg <= req_data;
    end
  end

  // Type decoding.
  vtls_type_decode #(
    .VECTOR_BITS  (VECTOR_BITS),
    .ELEMENT_BITS (ELEMENT_BITS),
    .LEN_W        (LEN_W)
  ) u_decode (
    .type_word          (req_reg.requested_type),
    .alt_format_ok_byte (alt_format_ok_byte),
    .alt_format_ok_half (alt_format_ok_half),
    .new_max            (new_max),
    .type_bad           (type_bad)
  );

  // Both flags clear means the length must stay, so the maximum may not change.
  assign keep_length = !req_reg.dest_nonzero && !req_reg.source_nonzero;
  assign illegal     = type_bad || (keep_length && new_max != current_max_length);

  // Type and maximum length update; an unchanged type skips the checks.
  always_comb begin
    current_type_next       = current_type;
    current_max_length_next = current_max_length;
    if (req_reg.requested_type != current_type) begin
      if (illegal) begin
        current_type_next       = vtls_pkg::illegal_pattern(integer_width);
        current_max_length_next = '0;
      end else begin
        current_type_next       = req_reg.requested_type;
        current_max_length_next = new_max;
      end
    end
  end

  // Length update from the flags and the new maximum.
  always_comb begin
    if (current_max_length_next == '0) begin
      current_length_next = '0;
    end else if (keep_length) begin
      current_length_next = current_length;
    end else if (!req_reg.source_nonzero) begin
      current_length_next = current_max_length_next;
    end else if (req_reg.requested_length < 64'(current_max_length_next)) begin
      current_length_next = LEN_W'(req_reg.requested_length);
    end else begin
      current_length_next = current_max_length_next;
    end
  end

  // Result beat, lengths reported in their low 9 bits.
  assign length_ext = (LEN_W + 9)'(current_length_next);
  assign max_ext    = (LEN_W + 9)'(current_max_length_next);

  always_comb begin
    res_data_next.new_length   = length_ext[vtls_pkg::OUT_LEN_W-1:0];
    res_data_next.type_value   = current_type_next;
    res_data_next.type_illegal =
      |current_type_next[vtls_pkg::TYPE_W-1:vtls_pkg::TYPE_RSVD_LSB];
    res_data_next.max_length   = max_ext[vtls_pkg::OUT_LEN_W-1:0];
  end

  // State registers commit as the beat moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_type       <= vtls_pkg::illegal_pattern(vtls_pkg::INTEGER_WIDTH_RESET);
      current_max_length <= '0;
      current_length     <= '0;
    end else if (advance && req_held) begin
      current_type       <= current_type_next;
      current_max_length <= current_max_length_next;
      current_length     <= current_length_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= req_held;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_held) begin
      res_data <= res_data_next;
    end
  end

endmodule

`default_nettype wire
